@@ src/scfp_pkg.sv @@
// shared types, codes and defaults of the serial command frame parser
package scfp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;

  localparam logic [7:0]  RST_SHORT_START = 8'hFE;
  localparam logic [7:0]  RST_LONG_START  = 8'hFC;
  localparam logic [7:0]  RST_SHORT_LEN   = 8'd7;
  localparam logic [15:0] RST_TIMEOUT     = 16'd200;

  localparam logic [2:0] ROLE_SHORT_PAYLOAD = 3'd0;
  localparam logic [2:0] ROLE_ADDRESS       = 3'd1;
  localparam logic [2:0] ROLE_COMMAND       = 3'd2;
  localparam logic [2:0] ROLE_LENGTH        = 3'd3;
  localparam logic [2:0] ROLE_LONG_PAYLOAD  = 3'd4;
  localparam logic [2:0] ROLE_END           = 3'd5;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHORT = 2'd1,
    PH_LHEAD = 2'd2,
    PH_LBODY = 2'd3
  } scfp_phase_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic       is_tick;
    logic       hit_short;
    logic       hit_long;
    logic [7:0] rx_byte;
  } scfp_item_t;

  typedef struct packed {
    logic       send_ack;
    logic       byte_valid;
    logic       frame_kind;
    logic [2:0] byte_role;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic       frame_last;
    logic       activity_on;
  } scfp_result_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } scfp_cfg_t;

endpackage

@@ src/serial_command_frame_parser.sv @@
// top level of the serial command frame parser
//
// input channel in_*: one transfer per received serial byte or time tick;
//   in_tuser selects the kind (0 byte, 1 tick), in_tdata carries the byte.
// output channel out_*: exactly one result transfer per input transfer, in
//   order; out_tdata holds the delivered byte and its payload index,
//   out_tuser the acknowledge, valid, kind, role and activity flags, and
//   out_tlast marks the final byte of a command frame.
// configuration port cfg_*: a write with cfg_we high sets the register at
//   cfg_idx (0 short start code, 1 long start code, 2 short length,
//   3 activity timeout); write only while no results are outstanding.
// path: each input transfer is written into the queue, and its result is
//   registered in the output register when the back end pops it from there.
// throughput: one item per cycle while out_tready stays high; the parser
//   state updates once per item in the back end.
// a queue of QUEUE_DEPTH classified items and one output register sit
//   between the channels; when out_tready is low the queue fills and
//   in_tready drops once it is full.
// reset clears the parse state, the activity timer, the queue and the output
//   valid flag, and reloads all registers with their default values.
module serial_command_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = scfp_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // rx_byte
  input  logic                            in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // out_byte, byte_index
  // send_ack, byte_valid, frame_kind, byte_role[2:0], activity_on
  output logic [6:0]                      out_tuser,
  output logic                            out_tlast   // frame_last
);

  scfp_pkg::scfp_cfg_t    cfg;
  scfp_pkg::scfp_item_t   push_item, head_item;
  scfp_pkg::scfp_result_t res;
  logic q_push, q_pop, q_full, q_not_empty;

  always_comb begin
    cfg.we   = cfg_we;
    cfg.idx  = cfg_idx;
    cfg.data = cfg_data;
  end

  scfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  scfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  scfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {res.byte_index, res.out_byte};
  assign out_tuser = {res.activity_on, res.byte_role, res.frame_kind,
                      res.byte_valid, res.send_ack};
  assign out_tlast = res.frame_last;

endmodule

@@ src/scfp_front.sv @@
// front end: takes input transfers and classifies bytes against the start codes
module scfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  scfp_pkg::scfp_cfg_t cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  input  logic                q_full,
  output logic                q_push,
  output scfp_pkg::scfp_item_t q_item
);

  logic [7:0] short_code_r, short_code_nxt;
  logic [7:0] long_code_r, long_code_nxt;

  always_comb begin
    short_code_nxt = short_code_r;
    long_code_nxt  = long_code_r;
    if (cfg.we) begin
      case (cfg.idx)
        scfp_pkg::CFG_SHORT_START: short_code_nxt = cfg.data[7:0];
        scfp_pkg::CFG_LONG_START:  long_code_nxt  = cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_code_r <= scfp_pkg::RST_SHORT_START;
      long_code_r  <= scfp_pkg::RST_LONG_START;
    end else begin
      short_code_r <= short_code_nxt;
      long_code_r  <= long_code_nxt;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_item.is_tick   = (in_tuser == scfp_pkg::FUNC_TICK);
    q_item.hit_short = (in_tdata == short_code_r);
    q_item.hit_long  = (in_tdata == long_code_r);
    q_item.rx_byte   = in_tdata;
  end

endmodule

@@ src/scfp_queue.sv @@
// short queue of classified items between front and back
module scfp_queue #(
  parameter int unsigned DEPTH = scfp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  scfp_pkg::scfp_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output scfp_pkg::scfp_item_t head_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  scfp_pkg::scfp_item_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ src/scfp_back.sv @@
// back end: frame parser, activity timer and output register
module scfp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scfp_pkg::scfp_cfg_t   cfg,
  input  logic                  q_not_empty,
  input  scfp_pkg::scfp_item_t  q_item,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output scfp_pkg::scfp_result_t res
);

  logic [7:0]  short_len_r, short_len_nxt;
  logic [15:0] timeout_r, timeout_nxt;

  scfp_pkg::scfp_phase_t phase_r, phase_nxt;
  logic [7:0]  bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  long_len_r, long_len_nxt;
  logic [15:0] quiet_r, quiet_nxt;
  logic        active_r, active_nxt;

  logic                   out_valid_r, out_valid_nxt;
  scfp_pkg::scfp_result_t out_r, out_nxt;
  logic [8:0]             short_next_cnt;

  assign q_pop     = q_not_empty && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    short_len_nxt = short_len_r;
    timeout_nxt   = timeout_r;
    if (cfg.we) begin
      case (cfg.idx)
        scfp_pkg::CFG_SHORT_LEN: short_len_nxt = cfg.data[7:0];
        scfp_pkg::CFG_TIMEOUT:   timeout_nxt   = cfg.data;
        default: ;
      endcase
    end
  end

  assign short_next_cnt = {1'b0, bytes_seen_r} + 9'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_seen_nxt = bytes_seen_r;
    long_len_nxt   = long_len_r;
    quiet_nxt      = quiet_r;
    active_nxt     = active_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (out_valid_r && res_ready) out_valid_nxt = 1'b0;

    if (q_pop) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (q_item.is_tick) begin
        if (quiet_r != 16'hFFFF) quiet_nxt = quiet_r + 16'd1;
        if (quiet_nxt > timeout_r) active_nxt = 1'b0;
      end else begin
        active_nxt = 1'b1;
        quiet_nxt  = '0;
        case (phase_r)
          scfp_pkg::PH_IDLE: begin
            // short code wins when both codes match
            if (q_item.hit_short) begin
              out_nxt.send_ack = 1'b1;
              phase_nxt        = scfp_pkg::PH_SHORT;
              bytes_seen_nxt   = '0;
            end else if (q_item.hit_long) begin
              out_nxt.send_ack = 1'b1;
              phase_nxt        = scfp_pkg::PH_LHEAD;
              bytes_seen_nxt   = '0;
            end
          end
          scfp_pkg::PH_SHORT: begin
            out_nxt.byte_valid = 1'b1;
            out_nxt.byte_role  = scfp_pkg::ROLE_SHORT_PAYLOAD;
            out_nxt.out_byte   = q_item.rx_byte;
            out_nxt.byte_index = bytes_seen_r;
            // a zero length behaves like one
            if (short_len_r == 8'd0 || short_next_cnt >= {1'b0, short_len_r}) begin
              out_nxt.frame_last = 1'b1;
              phase_nxt          = scfp_pkg::PH_IDLE;
              bytes_seen_nxt     = '0;
            end else begin
              bytes_seen_nxt = short_next_cnt[7:0];
            end
          end
          scfp_pkg::PH_LHEAD: begin
            out_nxt.byte_valid = 1'b1;
            out_nxt.frame_kind = 1'b1;
            out_nxt.out_byte   = q_item.rx_byte;
            if (bytes_seen_r == 8'd0) begin
              out_nxt.byte_role = scfp_pkg::ROLE_ADDRESS;
              bytes_seen_nxt    = 8'd1;
            end else if (bytes_seen_r == 8'd1) begin
              out_nxt.byte_role = scfp_pkg::ROLE_COMMAND;
              bytes_seen_nxt    = 8'd2;
            end else begin
              out_nxt.byte_role = scfp_pkg::ROLE_LENGTH;
              long_len_nxt      = q_item.rx_byte;
              bytes_seen_nxt    = '0;
              phase_nxt         = scfp_pkg::PH_LBODY;
            end
          end
          default: begin
            out_nxt.byte_valid = 1'b1;
            out_nxt.frame_kind = 1'b1;
            out_nxt.out_byte   = q_item.rx_byte;
            if (bytes_seen_r < long_len_r) begin
              out_nxt.byte_role  = scfp_pkg::ROLE_LONG_PAYLOAD;
              out_nxt.byte_index = bytes_seen_r;
              bytes_seen_nxt     = bytes_seen_r + 8'd1;
            end else begin
              out_nxt.byte_role  = scfp_pkg::ROLE_END;
              out_nxt.frame_last = 1'b1;
              phase_nxt          = scfp_pkg::PH_IDLE;
              bytes_seen_nxt     = '0;
            end
          end
        endcase
      end
      out_nxt.activity_on = active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_len_r  <= scfp_pkg::RST_SHORT_LEN;
      timeout_r    <= scfp_pkg::RST_TIMEOUT;
      phase_r      <= scfp_pkg::PH_IDLE;
      bytes_seen_r <= '0;
      long_len_r   <= '0;
      quiet_r      <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      short_len_r  <= short_len_nxt;
      timeout_r    <= timeout_nxt;
      phase_r      <= phase_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      long_len_r   <= long_len_nxt;
      quiet_r      <= quiet_nxt;
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_last_is_frame_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_last |-> out_r.byte_valid)
    else $error("frame_last without a frame byte");

  a_ack_not_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.send_ack |-> !out_r.byte_valid)
    else $error("acknowledge on a data byte");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == scfp_pkg::PH_IDLE |-> bytes_seen_r == 8'd0)
    else $error("byte count not cleared in idle");

  a_tick_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.is_tick |=> phase_r == $past(phase_r))
    else $error("tick changed the parse phase");

endmodule
